>>> design/b64_pkg.sv
// Shared types, constants and the alphabet lookup for the base64 stream encoder.
// Used by the queue, front, back and top-level files; depends on nothing.
package b64_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // One group of up to three bytes on its way to the character serializer.
    typedef struct packed {
        logic [23:0] bits;
        logic [2:0]  nchars;
        logic        last;
    } group_t;

    localparam logic [2:0] NCHARS_TWO   = 3'd2;
    localparam logic [2:0] NCHARS_THREE = 3'd3;
    localparam logic [2:0] NCHARS_FOUR  = 3'd4;

    function automatic logic [7:0] b64_char(input logic [5:0] idx);
        logic [7:0] code;
        code = {2'b00, idx};
        if (idx < 6'd26)
        begin
            b64_char = 8'h41 + code;
        end
        else if (idx < 6'd52)
        begin
            b64_char = 8'h61 + (code - 8'd26);
        end
        else if (idx < 6'd62)
        begin
            b64_char = 8'h30 + (code - 8'd52);
        end
        else if (idx == 6'd62)
        begin
            b64_char = 8'h2B;
        end
        else
        begin
            b64_char = 8'h2F;
        end
    endfunction

endpackage

>>> design/b64_stream_if.sv
// Valid/ready channel interfaces for raw bytes in and base64 characters out.
// Standalone; no package dependency.
interface b64_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       end_of_output;

    modport source (output valid, output out_char, output end_of_output, input ready);
    modport sink (input valid, input out_char, input end_of_output, output ready);
endinterface

>>> design/base64_stream_encoder.sv
// Base64 stream encoder: a closed group goes through the group queue to the output
// character register; characters then leave one per cycle while the output is ready, four
// per group. A byte is taken every cycle while the group queue has room; sustained input
// is limited by the single-character output register, four characters per three bytes.
// Reset (asynchronous, active low) clears pending bytes, the queue and output valid.
module base64_stream_encoder
    import b64_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    b64_byte_if.sink   raw_bytes,
    b64_char_if.source b64_chars
);

    logic   push;
    group_t push_data;
    logic   queue_full;
    logic   pop;
    group_t head;
    logic   queue_empty;

    b64_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .raw_bytes  (raw_bytes),
        .push       (push),
        .push_data  (push_data),
        .queue_full (queue_full)
    );

    b64_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (head),
        .empty     (queue_empty)
    );

    b64_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .queue_empty (queue_empty),
        .pop         (pop),
        .b64_chars   (b64_chars)
    );

endmodule

>>> design/b64_queue.sv
// Small group queue between the byte front end and the character back end.
// Depends on b64_pkg for the group_t entry type.
module b64_queue
    import b64_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  group_t push_data,
    output logic   full,
    input  logic   pop,
    output group_t pop_data,
    output logic   empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    group_t          entries [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   fill_reg;
    logic [CW-1:0]   fill_next;
    logic            do_push;
    logic            do_pop;

    assign full     = (fill_reg == CW'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> design/b64_front.sv
// Byte front end: gathers pending bytes and hands complete or final groups on.
// Depends on b64_pkg and the b64_byte_if interface.
module b64_front
    import b64_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    b64_byte_if.sink raw_bytes,
    output logic   push,
    output group_t push_data,
    input  logic   queue_full
);

    logic [15:0] pend_reg;
    logic [15:0] pend_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        accept;
    logic        emit;
    logic [7:0]  byte_in;

    assign byte_in         = raw_bytes.data_byte;
    assign raw_bytes.ready = !queue_full;
    assign accept          = raw_bytes.valid && !queue_full;
    // A third byte always closes the group, even when the message goes on.
    assign emit            = (count_reg >= 2'd2) || raw_bytes.final_byte;
    assign push            = accept && emit;

    always_comb
    begin
        push_data.last = raw_bytes.final_byte;
        if (count_reg >= 2'd2)
        begin
            push_data.bits   = {pend_reg, byte_in};
            push_data.nchars = NCHARS_FOUR;
        end
        else if (count_reg == 2'd1)
        begin
            push_data.bits   = {pend_reg[15:8], byte_in, 8'h00};
            push_data.nchars = NCHARS_THREE;
        end
        else
        begin
            push_data.bits   = {byte_in, 16'h0000};
            push_data.nchars = NCHARS_TWO;
        end
    end

    always_comb
    begin
        pend_next  = pend_reg;
        count_next = count_reg;
        if (accept)
        begin
            if (emit)
            begin
                pend_next  = '0;
                count_next = '0;
            end
            else
            begin
                if (count_reg == 2'd0)
                begin
                    pend_next = {byte_in, 8'h00};
                end
                else
                begin
                    pend_next = {pend_reg[15:8], byte_in};
                end
                count_next = count_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            pend_reg  <= pend_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> design/b64_back.sv
// Character back end: turns one queued group into four characters, one per beat.
// Depends on b64_pkg and the b64_char_if interface.
module b64_back
    import b64_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  group_t head,
    input  logic   queue_empty,
    output logic   pop,
    b64_char_if.source b64_chars
);

    logic [1:0] pos_reg;
    logic [1:0] pos_next;
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] char_reg;
    logic [7:0] char_next;
    logic       end_reg;
    logic       end_next;
    logic       load;
    logic [5:0] sextet;

    assign load = !queue_empty && (!valid_reg || b64_chars.ready);
    assign pop  = load && (pos_reg == 2'd3);

    assign b64_chars.valid         = valid_reg;
    assign b64_chars.out_char      = char_reg;
    assign b64_chars.end_of_output = end_reg;

    always_comb
    begin
        case (pos_reg)
            2'd0:    sextet = head.bits[23:18];
            2'd1:    sextet = head.bits[17:12];
            2'd2:    sextet = head.bits[11:6];
            default: sextet = head.bits[5:0];
        endcase
    end

    always_comb
    begin
        pos_next   = pos_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        end_next   = end_reg;
        if (load)
        begin
            pos_next   = pos_reg + 2'd1;
            valid_next = 1'b1;
            // Positions past the group's character count are padding.
            char_next  = ({1'b0, pos_reg} < head.nchars) ? b64_char(sextet) : PAD_CHAR;
            end_next   = head.last && (pos_reg == 2'd3);
        end
        else if (b64_chars.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        end_reg  <= end_next;
    end

endmodule

>>> design/b64_checker.sv
// Port-level checks for the base64 stream encoder, bound to the top level.
// Depends only on the top level's channel signals.
module b64_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       in_final,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_char,
    input logic       out_end
);

    logic [7:0] open_msgs_reg;
    logic [7:0] open_msgs_next;
    logic       pad_seen_reg;
    logic       pad_seen_next;
    logic       in_last_beat;
    logic       out_end_beat;

    assign in_last_beat = in_valid && in_ready && in_final;
    assign out_end_beat = out_valid && out_ready && out_end;

    // Count messages whose final byte went in but whose end character has not left.
    always_comb
    begin
        open_msgs_next = open_msgs_reg;
        if (in_last_beat && !out_end_beat)
        begin
            open_msgs_next = open_msgs_reg + 8'd1;
        end
        else if (out_end_beat && !in_last_beat)
        begin
            open_msgs_next = open_msgs_reg - 8'd1;
        end
        pad_seen_next = pad_seen_reg;
        if (out_valid && out_ready)
        begin
            pad_seen_next = (out_char == 8'h3D) && !out_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_msgs_reg <= '0;
            pad_seen_reg  <= 1'b0;
        end
        else
        begin
            open_msgs_reg <= open_msgs_next;
            pad_seen_reg  <= pad_seen_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_end))
        else $error("stalled output beat changed");

    a_end_has_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_end |-> open_msgs_reg != 8'd0)
        else $error("end of output without a final input byte");

    a_pad_runs_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pad_seen_reg |-> out_char == 8'h3D)
        else $error("character after padding is not padding");

    a_end_is_fourth: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pad_seen_reg && out_ready |-> out_end || out_char == 8'h3D)
        else $error("padding not closed by the message end");

endmodule

bind base64_stream_encoder b64_checker u_b64_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (raw_bytes.valid),
    .in_ready  (raw_bytes.ready),
    .in_final  (raw_bytes.final_byte),
    .out_valid (b64_chars.valid),
    .out_ready (b64_chars.ready),
    .out_char  (b64_chars.out_char),
    .out_end   (b64_chars.end_of_output)
);
